// ----- hdl/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg
// Shared codes and cell control/status types for the sorted key list.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

  typedef struct packed {
    logic le;
    logic lt;
    logic hit;
  } cell_stat_t;

endpackage

// ----- hdl/skl_if.sv -----
// ----------------------------------------------------------------------------
// skl_in_if / skl_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface skl_in_if #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
);
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [KEY_WIDTH-1:0]     key;
  logic [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skl_out_if #(
  parameter int PAYLOAD_WIDTH = 16,
  parameter int COUNT_WIDTH   = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [PAYLOAD_WIDTH-1:0] payload_out;
  logic [COUNT_WIDTH-1:0]   entry_count;

  modport source (output valid, output status, output payload_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input payload_out, input entry_count,
                  output ready);
endinterface

// ----- hdl/skl_cell.sv -----
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the sorted list: compares its entry against the beat key and
// keeps, loads the new pair, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module skl_cell #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  skl_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     occupied_i,
  input  logic [KEY_WIDTH-1:0]     key_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  logic                     left_le_i,
  input  logic [KEY_WIDTH-1:0]     left_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload_i,
  input  logic [KEY_WIDTH-1:0]     right_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload_i,
  output logic [KEY_WIDTH-1:0]     key_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o,
  output skl_pkg::cell_stat_t      stat_o
);

  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;

  always_comb begin
    stat_o.le  = occupied_i && ($signed(key_q) <= $signed(key_i));
    stat_o.lt  = occupied_i && ($signed(key_q) <  $signed(key_i));
    stat_o.hit = occupied_i && (key_q == key_i);
  end

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.ins && !stat_o.le) begin
      if (left_le_i) begin
        key_d = key_i;
        pay_d = payload_i;
      end else begin
        key_d = left_key_i;
        pay_d = left_payload_i;
      end
    end else if (ctrl_i.rem && !stat_o.lt) begin
      key_d = right_key_i;
      pay_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o     = key_q;
  assign payload_o = pay_q;

endmodule

// ----- hdl/sorted_key_list.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list
// An accepted operation beat's result beat is registered, valid in the next cycle.
// One beat per cycle unless stalled; all cells compare and shift in parallel.
// The result register frees as its beat is taken, so back-pressure stalls input.
// Reset clears the entry count and the result valid flag; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_list #(
  parameter int CAPACITY      = 16,
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skl_in_if.sink    in_i,
  skl_out_if.source out_o
);

  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

  logic [COUNT_WIDTH-1:0]   count_q, count_d;
  logic                     out_valid_q;
  logic [1:0]               status_q, status_d;
  logic [PAYLOAD_WIDTH-1:0] pout_q, pout_d;

  logic                     fire, full, found;
  skl_pkg::cell_ctrl_t      ctrl;

  logic [KEY_WIDTH-1:0]     cell_key     [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] cell_pay     [CAPACITY];
  skl_pkg::cell_stat_t      cell_stat    [CAPACITY];
  logic [CAPACITY-1:0]      hit_vec;
  logic [CAPACITY-1:0]      first_vec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign full       = (count_q == COUNT_WIDTH'(CAPACITY));
  assign found      = |hit_vec;

  assign ctrl.ins = fire && (in_i.op == skl_pkg::OP_INSERT) && !full;
  assign ctrl.rem = fire && (in_i.op == skl_pkg::OP_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     occ;
    logic                     l_le;
    logic [KEY_WIDTH-1:0]     l_key, r_key;
    logic [PAYLOAD_WIDTH-1:0] l_pay, r_pay;

    assign occ        = (COUNT_WIDTH'(i) < count_q);
    assign hit_vec[i] = cell_stat[i].hit;

    if (i == 0) begin : g_first
      assign l_le         = 1'b1;
      assign l_key        = '0;
      assign l_pay        = '0;
      assign first_vec[i] = cell_stat[i].hit;
    end else begin : g_mid
      assign l_le         = cell_stat[i-1].le;
      assign l_key        = cell_key[i-1];
      assign l_pay        = cell_pay[i-1];
      assign first_vec[i] = cell_stat[i].hit && !cell_stat[i-1].hit;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key = cell_key[i];
      assign r_pay = cell_pay[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_pay = cell_pay[i+1];
    end

    skl_cell #(
      .KEY_WIDTH    (KEY_WIDTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (occ),
      .key_i          (in_i.key),
      .payload_i      (in_i.payload),
      .left_le_i      (l_le),
      .left_key_i     (l_key),
      .left_payload_i (l_pay),
      .right_key_i    (r_key),
      .right_payload_i(r_pay),
      .key_o          (cell_key[i]),
      .payload_o      (cell_pay[i]),
      .stat_o         (cell_stat[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = skl_pkg::STATUS_DONE;
    pout_d   = '0;
    if (in_i.op == skl_pkg::OP_INSERT) begin
      if (full) begin
        status_d = skl_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
    end else begin
      if (!found) begin
        status_d = skl_pkg::STATUS_ABSENT;
      end else begin
        count_d = count_q - COUNT_WIDTH'(1);
        for (int j = 0; j < CAPACITY; j++) begin
          pout_d = pout_d | (cell_pay[j] & {PAYLOAD_WIDTH{first_vec[j]}});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      pout_q   <= pout_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.payload_out = pout_q;
  assign out_o.entry_count = count_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key list. A queued driver feeds insert
// and remove beats, a shadow list predicts each result at acceptance, and a
// monitor compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAPACITY      = 16;
  localparam int KEY_WIDTH     = 32;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int COUNT_WIDTH   = 5;
  localparam int NUM_BEATS     = 950;
  localparam int IDLE_PCT      = 13;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic                            op;
    logic signed [KEY_WIDTH-1:0]     key;
    logic        [PAYLOAD_WIDTH-1:0] payload;
    bit                              drain;
  } op_beat_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [PAYLOAD_WIDTH-1:0] payload_out;
    logic [COUNT_WIDTH-1:0]   entry_count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  skl_in_if  #(.KEY_WIDTH(KEY_WIDTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) in_if ();
  skl_out_if #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) out_if ();

  sorted_key_list #(
    .CAPACITY     (CAPACITY),
    .KEY_WIDTH    (KEY_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  op_beat_t     op_q[$];
  list_result_t due_results[$];
  op_beat_t     on_bus;

  logic signed [KEY_WIDTH-1:0]     shadow_keys [CAPACITY];
  logic        [PAYLOAD_WIDTH-1:0] shadow_pays [CAPACITY];
  int                              shadow_count = 0;

  int beats_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycles       = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic apply_to_shadow_list(input op_beat_t b, output list_result_t r);
    int pos;
    r = '0;
    r.status = skl_pkg::STATUS_DONE;
    if (b.op == skl_pkg::OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = skl_pkg::STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] <= b.key) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[pos] = b.key;
        shadow_pays[pos] = b.payload;
        shadow_count++;
      end
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] != b.key) pos++;
      if (pos >= shadow_count) begin
        r.status = skl_pkg::STATUS_ABSENT;
      end else begin
        r.payload_out = shadow_pays[pos];
        for (int i = pos; i < shadow_count - 1; i++) begin
          shadow_keys[i] = shadow_keys[i+1];
          shadow_pays[i] = shadow_pays[i+1];
        end
        shadow_count--;
      end
    end
    r.entry_count = shadow_count[COUNT_WIDTH-1:0];
  endtask

  task automatic add_beat(input logic op, input logic signed [KEY_WIDTH-1:0] key,
                          input logic [PAYLOAD_WIDTH-1:0] payload, input bit drain);
    op_beat_t b;
    b.op      = op;
    b.key     = key;
    b.payload = payload;
    b.drain   = drain;
    op_q.push_back(b);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    list_result_t r;
    bit           calm;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.op      <= skl_pkg::OP_INSERT;
      in_if.key     <= '0;
      in_if.payload <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_to_shadow_list(on_bus, r);
        due_results.push_back(r);
        beats_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        calm = (beats_sent >= 300 && beats_sent < 450);
        if (op_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
            !(op_q[0].drain && due_results.size() != 0)) begin
          on_bus         = op_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.op      <= on_bus.op;
          in_if.key     <= on_bus.key;
          in_if.payload <= on_bus.payload;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status      = out_if.status;
        got.payload_out = out_if.payload_out;
        got.entry_count = out_if.entry_count;
        results_seen++;
        if (due_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: status=%0d payload_out=%h entry_count=%0d",
                     got.status, got.payload_out, got.entry_count);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.payload_out !== want.payload_out ||
              got.entry_count !== want.entry_count) begin
            if (mismatches < MAX_REPORTS) begin
              $display("result %0d: expected status=%0d payload_out=%h entry_count=%0d",
                       results_seen, want.status, want.payload_out, want.entry_count);
              $display("result %0d: got      status=%0d payload_out=%h entry_count=%0d",
                       results_seen, got.status, got.payload_out, got.entry_count);
            end
            mismatches++;
          end
        end
      end
      out_if.ready <= (results_seen >= 300 && results_seen < 450) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [KEY_WIDTH-1:0] pool [6];
    logic signed [KEY_WIDTH-1:0] key;
    logic                        op;
    int                          mode;
    int                          ins_pct;
    int                          seg;
    int                          pick;

    rst_ni = 1'b0;

    // empty store, single entry in and out, extremes, duplicates
    add_beat(skl_pkg::OP_REMOVE, 5, 16'h0000, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 7, 16'h00A5, 1'b0);
    add_beat(skl_pkg::OP_REMOVE, 7, 16'h0000, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 32'sh8000_0000, 16'h0000, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 0, 16'h1111, 1'b0);
    add_beat(skl_pkg::OP_INSERT, -1, 16'h2222, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 0, 16'h3333, 1'b0);
    add_beat(skl_pkg::OP_INSERT, 0, 16'h4444, 1'b0);
    add_beat(skl_pkg::OP_REMOVE, 0, 16'hBEEF, 1'b0);
    add_beat(skl_pkg::OP_REMOVE, 1, 16'hFFFF, 1'b0);
    add_beat(skl_pkg::OP_REMOVE, 32'sh8000_0000, 16'h0000, 1'b0);
    // fill to capacity, then one refused insert and a remove at the tail
    for (int i = 0; i < CAPACITY - 4; i++)
      add_beat(skl_pkg::OP_INSERT, 32'sh8000_0000 + i * 32'sh0111_1111,
               16'(i * 16'h1357), 1'b0);
    add_beat(skl_pkg::OP_INSERT, 3, 16'h5A5A, 1'b0);
    add_beat(skl_pkg::OP_REMOVE, 32'sh7FFF_FFFF, 16'h0000, 1'b0);

    seg = 0;
    while (op_q.size() < NUM_BEATS) begin
      mode = $urandom_range(0, 3);
      for (int p = 0; p < 6; p++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      pool[p] = 32'sh8000_0000;
        else if (pick == 1) pool[p] = 32'sh7FFF_FFFF;
        else if (pick < 5)  pool[p] = int'($urandom_range(0, 15)) - 8;
        else                pool[p] = $urandom;
      end
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      for (int k = 0; k < 40; k++) begin
        op  = ($urandom_range(0, 99) < ins_pct) ? skl_pkg::OP_INSERT : skl_pkg::OP_REMOVE;
        key = (mode == 3 || $urandom_range(0, 9) == 0) ? $urandom
                                                        : pool[$urandom_range(0, 5)];
        add_beat(op, key, 16'($urandom), (k == 0) && (seg % 5 == 4));
      end
      seg++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/skl_pkg.sv
hdl/skl_if.sv
hdl/skl_cell.sv
hdl/sorted_key_list.sv
tb/tb_top.sv
